FILE: src/pcpa_pkg.sv
// Package for the per-CPU page allocator: payload structs, codes, defaults.
// Used by the datapath, controller and top level in src.
package pcpa_pkg;
  localparam int CpuCountDef  = 8;
  localparam int PageCountDef = 32768;
  localparam int PageShiftDef = 12;
  localparam int AddrW = 40;

  localparam logic       OP_FREE  = 1'b0;
  localparam logic       OP_ALLOC = 1'b1;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [1:0] REG_LOW   = 2'd0;
  localparam logic [1:0] REG_HIGH  = 2'd1;
  localparam logic [1:0] REG_STEAL = 2'd2;

  localparam logic [39:0] HighReset  = 40'd2281701376;
  localparam logic [15:0] StealReset = 16'd128;

  typedef struct packed {
    logic        operation;
    logic [2:0]  cpu;
    logic [39:0] address;
  } in_word_t;

  typedef struct packed {
    logic [39:0] page_address;
    logic [1:0]  status;
  } out_word_t;

  // datapath commands
  typedef struct packed {
    logic load;     // capture input word
    logic rd_head;  // read link of own head into rdata
    logic push;     // push free page
    logic pop;      // pop own head using rdata
    logic mv;       // move head of cur to own using rdata
    logic next_cpu; // advance cur
    logic emit;     // result valid
    logic empty;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic bad;
    logic own_empty;
    logic cur_nonempty;
    logic cur_is_own;
    logic cur_last;
    logic left_zero;
    logic moved;
  } sts_t;
endpackage

FILE: src/pcpa_ram.sv
// Generic RAM with one write port and one registered read port.
// No dependencies.
module pcpa_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: src/pcpa_datapath.sv
// Datapath: list heads, link memory, address check and result register.
// Depends on pcpa_pkg and pcpa_ram.
module pcpa_datapath #(
  parameter int CpuCount  = pcpa_pkg::CpuCountDef,
  parameter int PageCount = pcpa_pkg::PageCountDef,
  parameter int PageShift = pcpa_pkg::PageShiftDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcpa_pkg::in_word_t in_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [39:0]        cfg_data_i,
  input  pcpa_pkg::cmd_t     cmd_i,
  output pcpa_pkg::sts_t     sts_o,
  output pcpa_pkg::out_word_t res_o
);
  localparam int CW = (CpuCount > 1) ? $clog2(CpuCount) : 1;
  localparam int IW = $clog2(PageCount);
  localparam int HW = $clog2(PageCount + 1);
  localparam logic [39:0] Mask = (40'd1 << PageShift) - 40'd1;

  logic [39:0] low_q, high_q;
  logic [15:0] steal_q, left_q, left_d;
  logic [HW-1:0] heads_q [CpuCount];
  logic [CW-1:0] me_q, cur_q;
  logic op_q;
  logic [39:0] addr_q;
  logic moved_q;
  logic [HW-1:0] rdata;
  pcpa_pkg::out_word_t res_q;

  logic [39:0] base, off;
  logic [31:0] cpu_rem;
  logic [CW-1:0] me_in;
  logic [HW-1:0] own_h, cur_h;
  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [HW-1:0] wdata;

  always_comb begin
    cpu_rem = 32'(in_i.cpu);
    for (int k = 0; k < 8; k++) begin
      if (cpu_rem >= 32'(CpuCount)) cpu_rem = cpu_rem - 32'(CpuCount);
    end
  end

  assign base  = (low_q + Mask) & ~Mask;
  assign off   = addr_q - base;
  assign me_in = CW'(cpu_rem);
  assign own_h = heads_q[me_q];
  assign cur_h = heads_q[cur_q];

  always_comb begin
    sts_o.is_alloc     = op_q == pcpa_pkg::OP_ALLOC;
    sts_o.bad          = ((addr_q & Mask) != 40'd0) || addr_q < low_q ||
                         addr_q >= high_q || addr_q < base ||
                         (off >> PageShift) >= 40'(PageCount);
    sts_o.own_empty    = own_h == '0;
    sts_o.cur_nonempty = cur_h != '0;
    sts_o.cur_is_own   = cur_q == me_q;
    sts_o.cur_last     = 32'(cur_q) == CpuCount - 1;
    sts_o.left_zero    = left_q == 16'd0;
    sts_o.moved        = moved_q;
  end

  always_comb begin
    we = 1'b0; waddr = '0; wdata = own_h;
    raddr = IW'(cur_h - HW'(1));
    if (cmd_i.push) begin
      we = 1'b1; waddr = IW'(off >> PageShift);
    end else if (cmd_i.mv) begin
      we = 1'b1; waddr = IW'(cur_h - HW'(1));
    end
    if (cmd_i.rd_head) raddr = IW'(own_h - HW'(1));
    if (cmd_i.load) raddr = IW'(heads_q[me_in] - HW'(1));
  end

  pcpa_ram #(.Width(HW), .Depth(PageCount)) u_link (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    left_d = left_q;
    if (cmd_i.load) left_d = steal_q;
    else if (cmd_i.mv) left_d = left_q - 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= '0; high_q <= pcpa_pkg::HighReset; steal_q <= pcpa_pkg::StealReset;
      for (int i = 0; i < CpuCount; i++) heads_q[i] <= '0;
      me_q <= '0; cur_q <= '0; op_q <= 1'b0; left_q <= '0; moved_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pcpa_pkg::REG_LOW:   low_q   <= cfg_data_i;
          pcpa_pkg::REG_HIGH:  high_q  <= cfg_data_i;
          pcpa_pkg::REG_STEAL: steal_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      left_q <= left_d;
      if (cmd_i.load) begin
        me_q <= me_in; cur_q <= '0; op_q <= in_i.operation; moved_q <= 1'b0;
      end
      if (cmd_i.next_cpu) cur_q <= cur_q + CW'(1);
      if (cmd_i.push) heads_q[me_q] <= HW'(off >> PageShift) + HW'(1);
      if (cmd_i.pop) heads_q[me_q] <= rdata;
      if (cmd_i.mv) begin
        heads_q[cur_q] <= rdata;
        heads_q[me_q]  <= cur_h;
        moved_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) addr_q <= in_i.address;
    if (cmd_i.emit) begin
      res_q.page_address <= '0;
      res_q.status <= pcpa_pkg::ST_OK;
      if (!sts_o.is_alloc) begin
        if (sts_o.bad) res_q.status <= pcpa_pkg::ST_BAD;
      end else if (cmd_i.empty) begin
        res_q.status <= pcpa_pkg::ST_EMPTY;
      end else begin
        res_q.page_address <= base + (40'(own_h - HW'(1)) << PageShift);
      end
    end
  end
  assign res_o = res_q;
endmodule

FILE: src/pcpa_ctrl.sv
// Controller state machine sequencing free, pop and steal walk.
// Depends on pcpa_pkg.
module pcpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  pcpa_pkg::sts_t sts_i,
  output pcpa_pkg::cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_RD = 3'd2,
                         S_STEP = 3'd3, S_POPRD = 3'd4;
  logic [2:0] st_q, st_d;
  logic ov_q, ov_d;
  logic accept;

  assign in_stall_o  = !(st_q == S_IDLE && (!ov_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o = '0; st_d = st_q;
    ov_d = ov_q && out_stall_i;
    unique case (st_q)
      S_IDLE: if (accept) begin
        cmd_o.load = 1'b1; st_d = S_EXEC;
      end
      S_EXEC: begin
        if (!sts_i.is_alloc) begin
          cmd_o.push = !sts_i.bad; cmd_o.emit = 1'b1; ov_d = 1'b1; st_d = S_IDLE;
        end else if (!sts_i.own_empty) begin
          cmd_o.rd_head = 1'b1; st_d = S_POPRD;
        end else st_d = S_STEP;
      end
      S_RD: st_d = S_STEP;
      S_STEP: begin
        if (!sts_i.cur_is_own && sts_i.cur_nonempty && !sts_i.left_zero) begin
          cmd_o.mv = 1'b1; st_d = S_RD;
        end else if (sts_i.moved || sts_i.cur_last) begin
          if (sts_i.own_empty) begin
            cmd_o.emit = 1'b1; cmd_o.empty = 1'b1; ov_d = 1'b1; st_d = S_IDLE;
          end else begin
            cmd_o.rd_head = 1'b1; st_d = S_POPRD;
          end
        end else begin
          cmd_o.next_cpu = 1'b1; st_d = S_RD;
        end
      end
      S_POPRD: begin
        cmd_o.pop = 1'b1; cmd_o.emit = 1'b1; ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d;
    end
  end
endmodule

FILE: src/per_cpu_page_allocator.sv
// Per-CPU page allocator top level: controller plus datapath.
// Free: load state, then execute state. Allocate from own list: load, execute, pop-read.
// A steal alternates step and link read states per page moved or CPU passed, then pops.
// One item at a time; next item accepted once the result register is free.
// Reset empties every list and loads register defaults; link memory is not cleared.
module per_cpu_page_allocator #(
  parameter int CpuCount  = pcpa_pkg::CpuCountDef,
  parameter int PageCount = pcpa_pkg::PageCountDef,
  parameter int PageShift = pcpa_pkg::PageShiftDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcpa_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcpa_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [39:0]         cfg_data_i
);
  pcpa_pkg::cmd_t cmd;
  pcpa_pkg::sts_t sts;
  assign cfg_ready_o = 1'b1;

  pcpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pcpa_datapath #(.CpuCount(CpuCount), .PageCount(PageCount), .PageShift(PageShift))
  u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cfg_we_i(cfg_valid_i),
    .cfg_idx_i(cfg_index_i), .cfg_data_i, .cmd_i(cmd), .sts_o(sts), .res_o(out_data_o)
  );

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.push, cmd.pop, cmd.mv})) else $error("conflicting list ops");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mv |-> in_stall_o) else $error("accept during steal");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o) else $error("result lost");
endmodule

FILE: bench/pcpa_checker.sv
// Checker for the per-CPU page allocator: watches the input, result and register channels,
// predicts each result word and compares it. Depends on pcpa_pkg.
module pcpa_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  pcpa_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  pcpa_pkg::out_word_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [39:0]         cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cpus  = pcpa_pkg::CpuCountDef;
  localparam int Pages = pcpa_pkg::PageCountDef;
  localparam int Shift = pcpa_pkg::PageShiftDef;
  localparam logic [63:0] PageMask = (64'd1 << Shift) - 64'd1;

  logic [15:0] next_code [Pages];
  logic [15:0] head_code [Cpus];
  logic [39:0] low_q, high_q;
  logic [15:0] steal_q;
  pcpa_pkg::out_word_t expected_words[$];

  function automatic logic [15:0] link_of(logic [15:0] code);
    if (code == 16'd0 || code > Pages) return 16'd0;
    return next_code[code - 16'd1];
  endfunction

  task automatic allot_page(input pcpa_pkg::in_word_t w, output pcpa_pkg::out_word_t r);
    int unsigned me;
    logic [63:0] addr, base, idx;
    logic [31:0] left;
    logic [15:0] pg;
    me = w.cpu % Cpus;
    addr = {24'd0, w.address};
    base = ({24'd0, low_q} + PageMask) & ~PageMask;
    r = '0;
    if (w.operation == pcpa_pkg::OP_FREE) begin
      idx = (addr - base) >> Shift;
      if ((addr & PageMask) != 0 || addr < low_q || addr >= high_q || addr < base ||
          idx >= Pages) begin
        r.status = pcpa_pkg::ST_BAD;
      end else begin
        next_code[idx] = head_code[me];
        head_code[me] = 16'(idx + 1);
        r.status = pcpa_pkg::ST_OK;
      end
      return;
    end
    if (head_code[me] == 0) begin
      left = steal_q;
      for (int i = 0; i < Cpus && head_code[me] == 0; i++) begin
        if (i == me) continue;
        while (left != 0 && head_code[i] != 0) begin
          pg = head_code[i];
          head_code[i] = link_of(pg);
          if (pg != 0 && pg <= Pages) next_code[pg - 1] = head_code[me];
          head_code[me] = pg;
          left--;
        end
      end
    end
    if (head_code[me] == 0) begin
      r.status = pcpa_pkg::ST_EMPTY;
    end else begin
      pg = head_code[me];
      head_code[me] = link_of(pg);
      r.page_address = 40'(base + (64'(pg - 16'd1) << Shift));
      r.status = pcpa_pkg::ST_OK;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pcpa_pkg::out_word_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < Cpus; i++) head_code[i] = '0;
      low_q = '0;
      high_q = pcpa_pkg::HighReset;
      steal_q = pcpa_pkg::StealReset;
      expected_words.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pcpa_pkg::REG_LOW:   low_q = cfg_data_i;
          pcpa_pkg::REG_HIGH:  high_q = cfg_data_i;
          pcpa_pkg::REG_STEAL: steal_q = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        allot_page(in_data_i, want);
        expected_words.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, got);
          errors_o++;
        end else begin
          want = expected_words.pop_front();
          if (got.page_address !== want.page_address) begin
            $display("%0t: page_address expected %h actual %h", $time, want.page_address,
                     got.page_address);
            errors_o++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %h actual %h", $time, want.status, got.status);
            errors_o++;
          end
        end
      end
      pending_o = expected_words.size();
    end
  end
endmodule

FILE: bench/tb_per_cpu_page_allocator.sv
// Top of the per-CPU page allocator bench: clock, reset, stimulus and verdict.
// Depends on pcpa_pkg, per_cpu_page_allocator and pcpa_checker.
module tb_per_cpu_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam logic [39:0] AddrMax = 40'hFF_FFFF_FFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pcpa_pkg::in_word_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pcpa_pkg::out_word_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = pcpa_pkg::REG_LOW;
  logic [39:0]         cfg_data_i = '0;
  int                  errors, pending, cycles = 0;
  logic [39:0]         low_now = '0;
  int                  fresh_page = 3;
  bit                  calm = 1'b0;
  int                  stall_left = 0;

  per_cpu_page_allocator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i,
    .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  pcpa_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i, .out_valid_i(out_valid_o),
    .out_stall_i, .out_data_i(out_data_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("per_cpu_page_allocator: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
    end
  end

  function automatic logic [39:0] page_addr(int idx);
    logic [63:0] base;
    base = ({24'd0, low_now} + 64'hFFF) & ~64'hFFF;
    return 40'(base + (64'(idx) << 12));
  endfunction

  task automatic send_word(logic op, logic [2:0] cpu, logic [39:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{operation: op, cpu: cpu, address: addr};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] val);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == pcpa_pkg::REG_LOW) low_now = val;
  endtask

  task automatic random_words(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_word(pcpa_pkg::OP_ALLOC, 3'($urandom), {$urandom, 8'($urandom)});
      end else if (r < 85) begin
        send_word(pcpa_pkg::OP_FREE, 3'($urandom), page_addr(fresh_page));
        fresh_page++;
      end else if (r < 93) begin
        send_word(pcpa_pkg::OP_FREE, 3'($urandom), {$urandom, 8'($urandom)} | 40'h1);
      end else begin
        send_word(pcpa_pkg::OP_FREE, 3'($urandom),
                  page_addr(32768 + $urandom_range(0, 100000)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(pcpa_pkg::OP_ALLOC, 3'd0, '0);
    send_word(pcpa_pkg::OP_FREE, 3'd0, 40'h1001);
    send_word(pcpa_pkg::OP_FREE, 3'd0, 40'h88000000);
    send_word(pcpa_pkg::OP_FREE, 3'd0, 40'h8000000);
    send_word(pcpa_pkg::OP_FREE, 3'd7, 40'hFF_FFFF_F000);
    send_word(pcpa_pkg::OP_FREE, 3'd1, page_addr(0));
    send_word(pcpa_pkg::OP_FREE, 3'd2, page_addr(32767));
    send_word(pcpa_pkg::OP_FREE, 3'd2, page_addr(1));
    send_word(pcpa_pkg::OP_FREE, 3'd3, page_addr(2));
    send_word(pcpa_pkg::OP_ALLOC, 3'd2, AddrMax);
    repeat (4) send_word(pcpa_pkg::OP_ALLOC, 3'd5, '0);
    random_words(95);

    write_reg(pcpa_pkg::REG_HIGH, AddrMax);
    write_reg(pcpa_pkg::REG_STEAL, 40'd1);
    send_word(pcpa_pkg::OP_FREE, 3'd0, page_addr(fresh_page));
    send_word(pcpa_pkg::OP_FREE, 3'd0, page_addr(fresh_page));
    fresh_page++;
    send_word(pcpa_pkg::OP_ALLOC, 3'd1, '0);
    send_word(pcpa_pkg::OP_ALLOC, 3'd0, '0);
    send_word(pcpa_pkg::OP_ALLOC, 3'd0, '0);
    random_words(95);

    write_reg(pcpa_pkg::REG_LOW, 40'h1_2345_6789);
    write_reg(pcpa_pkg::REG_STEAL, 40'd0);
    send_word(pcpa_pkg::OP_FREE, 3'd4, 40'h1_2345_6000);
    random_words(90);

    write_reg(pcpa_pkg::REG_LOW, 40'hFF_F800_0000);
    write_reg(pcpa_pkg::REG_STEAL, 40'hFFFF);
    send_word(pcpa_pkg::OP_FREE, 3'd6, 40'hFF_FFFF_F000);
    random_words(95);

    write_reg(pcpa_pkg::REG_LOW, 40'h1000);
    write_reg(pcpa_pkg::REG_HIGH, 40'h1000_0000);
    write_reg(pcpa_pkg::REG_STEAL, 40'd3);
    random_words(95);

    write_reg(pcpa_pkg::REG_LOW, AddrMax);
    write_reg(pcpa_pkg::REG_HIGH, '0);
    write_reg(pcpa_pkg::REG_STEAL, 40'd128);
    random_words(30);
    write_reg(pcpa_pkg::REG_LOW, '0);
    random_words(40);

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("per_cpu_page_allocator: match");
    end else begin
      $display("per_cpu_page_allocator: mismatch");
    end
    $finish;
  end
endmodule

FILE: per_cpu_page_allocator.f
src/pcpa_pkg.sv
src/pcpa_ram.sv
src/pcpa_datapath.sv
src/pcpa_ctrl.sv
src/per_cpu_page_allocator.sv
bench/pcpa_checker.sv
bench/tb_per_cpu_page_allocator.sv
